// File: sv/assert_macros.svh
// Assertion macros shared by the rate-limit probe RTL.
// Defined empty when SYNTH is set, so synthesis sees no assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: sv/rlhs_pkg.sv
// Shared constants and controller/datapath interface types for the
// rate-limit hash set probe. No dependencies.
`default_nettype none

package rlhs_pkg;

	localparam int SLOTS     = 1024;
	localparam int KEY_BITS  = 64;
	localparam int ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int DATA_W    = 64;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int HASH_W    = 32;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = HASH_W / DIV_BITS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INSERT_BUDGET = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] SLOT_COUNT_RST    = CFG_W'(1024);
	localparam logic [CFG_W-1:0] INSERT_BUDGET_RST = CFG_W'(1024);

	typedef struct packed {
		logic clr_wr;
		logic load;
		logic div_step;
		logic rd_en;
		logic advance;
		logic insert;
		logic res_set;
		logic res_acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic count_zero;
		logic div_last;
		logic slot_empty;
		logic slot_match;
		logic budget_ok;
		logic probe_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/rate_limit_hash_set_probe_top.sv
// Rate-limit probe on a linear-probing hash set of query keys; top level.
// Per query: accept, then reduce the key's low 32 bits modulo the slot count
// (4 bits a cycle), then per probe a RAM read and a compare, then load the
// output word once the output register is free.
// After reset a clearing pass over all 1024 slots empties the key RAM; input stalls.
// Depends on rlhs_pkg, rlhs_ctrl, rlhs_dp, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rate_limit_hash_set_probe_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rlhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlhs_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [rlhs_pkg::DATA_W-1:0]     query_key,
	input  wire logic [rlhs_pkg::DATA_W-1:0]     phone_in,
	input  wire logic                            batch_last,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 rate_limited,
	output logic [rlhs_pkg::DATA_W-1:0]          phone_out,
	output logic                                 batch_last_out
);

	rlhs_pkg::cmd_t cmd;
	rlhs_pkg::sts_t sts;

	rlhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	rlhs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.query_key      (query_key),
		.phone_in       (phone_in),
		.batch_last     (batch_last),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.rate_limited   (rate_limited),
		.phone_out      (phone_out),
		.batch_last_out (batch_last_out)
	);

	`ASSERT_ALWAYS(a_insert_gated, clk, arst_n, cmd.insert |-> (sts.slot_empty && sts.budget_ok))
	`ASSERT_ALWAYS(a_result_lands, clk, arst_n, cmd.out_load |=> out_valid)
	`ASSERT_NEVER(a_idle_no_probe, clk, arst_n, !in_stall && (cmd.rd_en || cmd.insert || cmd.clr_wr))
	`ASSERT_ALWAYS(a_limited_zero, clk, arst_n, (out_valid && rate_limited) |-> (phone_out == '0))

endmodule

`default_nettype wire

// File: sv/rlhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlhs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/rlhs_ctrl.sv
// Sequencer for the probe: clearing pass, start-slot division, probe walk
// and result hand-off. Depends on rlhs_pkg.
`default_nettype none

module rlhs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire rlhs_pkg::sts_t sts,
	output rlhs_pkg::cmd_t     cmd,
	output logic               in_stall
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.count_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_acc = 1'b0;
					state_nxt   = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) begin
						state_nxt = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.slot_empty) begin
					cmd.res_set = 1'b1;
					cmd.res_acc = sts.budget_ok;
					cmd.insert  = sts.budget_ok;
					state_nxt   = S_DONE;
				end else if (sts.slot_match) begin
					cmd.res_set = 1'b1;
					cmd.res_acc = 1'b1;
					state_nxt   = S_DONE;
				end else if (sts.probe_last) begin
					cmd.res_set = 1'b1;
					cmd.res_acc = 1'b0;
					state_nxt   = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_nxt   = S_READ;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// File: sv/rlhs_dp.sv
// Datapath: configuration registers, radix-16 start-slot divider, probe
// counters, key store and output word register. Depends on rlhs_pkg, rlhs_ram.
`default_nettype none

module rlhs_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rlhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlhs_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic [rlhs_pkg::DATA_W-1:0]     query_key,
	input  wire logic [rlhs_pkg::DATA_W-1:0]     phone_in,
	input  wire logic                            batch_last,
	input  wire logic                            out_stall,
	input  wire rlhs_pkg::cmd_t                  cmd,
	output rlhs_pkg::sts_t                       sts,
	output logic                                 out_valid,
	output logic                                 rate_limited,
	output logic [rlhs_pkg::DATA_W-1:0]          phone_out,
	output logic                                 batch_last_out
);

	logic [rlhs_pkg::CFG_W-1:0]    slot_count_q;
	logic [rlhs_pkg::CFG_W-1:0]    insert_budget_q;
	logic [rlhs_pkg::CFG_W-1:0]    used_q;
	logic [rlhs_pkg::ADDR_W-1:0]   clr_q;
	logic [rlhs_pkg::STEP_W-1:0]   step_q;
	logic                          out_valid_q;

	logic [rlhs_pkg::KEY_BITS-1:0] key_q;
	logic [rlhs_pkg::DATA_W-1:0]   phone_q;
	logic                          last_q;
	logic [rlhs_pkg::HASH_W-1:0]   div_q;
	logic [rlhs_pkg::CNT_W-1:0]    rem_q;
	logic [rlhs_pkg::ADDR_W-1:0]   idx_q;
	logic [rlhs_pkg::CNT_W-1:0]    n_q;
	logic                          acc_q;
	logic                          out_lim_q;
	logic [rlhs_pkg::DATA_W-1:0]   out_phone_q;
	logic                          out_last_q;

	logic [rlhs_pkg::CNT_W-1:0]    count;
	logic [rlhs_pkg::CNT_W-1:0]    rem_nxt;
	logic [rlhs_pkg::HASH_W-1:0]   div_nxt;
	logic [rlhs_pkg::CNT_W-1:0]    idx_inc;
	logic [rlhs_pkg::CNT_W-1:0]    n_inc;
	logic [rlhs_pkg::KEY_BITS-1:0] rd_data;

	logic                          ram_we;
	logic [rlhs_pkg::ADDR_W-1:0]   ram_waddr;
	logic [rlhs_pkg::KEY_BITS-1:0] ram_wdata;

	always_comb begin
		if (32'(slot_count_q) > 32'(rlhs_pkg::SLOTS)) begin
			count = rlhs_pkg::CNT_W'(rlhs_pkg::SLOTS);
		end else begin
			count = rlhs_pkg::CNT_W'(slot_count_q);
		end
	end

	// restoring division, DIV_BITS quotient bits a cycle; only the remainder is kept
	always_comb begin
		logic [rlhs_pkg::CNT_W:0]    t;
		logic [rlhs_pkg::CNT_W-1:0]  r;
		logic [rlhs_pkg::HASH_W-1:0] d;
		r = rem_q;
		d = div_q;
		t = '0;
		for (int i = 0; i < rlhs_pkg::DIV_BITS; i++) begin
			t = {r, d[rlhs_pkg::HASH_W-1]};
			d = {d[rlhs_pkg::HASH_W-2:0], 1'b0};
			if (t >= {1'b0, count}) begin
				t = t - {1'b0, count};
			end
			r = t[rlhs_pkg::CNT_W-1:0];
		end
		rem_nxt = r;
		div_nxt = d;
	end

	assign idx_inc = rlhs_pkg::CNT_W'(idx_q) + rlhs_pkg::CNT_W'(1);
	assign n_inc   = n_q + rlhs_pkg::CNT_W'(1);

	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_q == rlhs_pkg::ADDR_W'(rlhs_pkg::SLOTS - 1));
		sts.count_zero = (count == '0);
		sts.div_last   = (step_q == rlhs_pkg::STEP_W'(rlhs_pkg::DIV_STEPS - 1));
		sts.slot_empty = (rd_data == '0);
		sts.slot_match = (rd_data == key_q);
		sts.budget_ok  = (used_q < insert_budget_q);
		sts.probe_last = (n_inc == count);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign ram_we    = cmd.clr_wr || cmd.insert;
	assign ram_waddr = cmd.clr_wr ? clr_q : idx_q;
	assign ram_wdata = cmd.clr_wr ? '0 : key_q;

	rlhs_ram #(
		.WIDTH (rlhs_pkg::KEY_BITS),
		.DEPTH (rlhs_pkg::SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q    <= rlhs_pkg::SLOT_COUNT_RST;
			insert_budget_q <= rlhs_pkg::INSERT_BUDGET_RST;
			used_q          <= '0;
			clr_q           <= '0;
			step_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rlhs_pkg::REG_SLOT_COUNT:    slot_count_q    <= cfg_data;
					rlhs_pkg::REG_INSERT_BUDGET: insert_budget_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + rlhs_pkg::ADDR_W'(1);
			end
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + rlhs_pkg::STEP_W'(1);
			end
			if (cmd.insert) begin
				used_q <= used_q + rlhs_pkg::CFG_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= query_key[rlhs_pkg::KEY_BITS-1:0];
			phone_q <= phone_in;
			last_q  <= batch_last;
			div_q   <= query_key[rlhs_pkg::HASH_W-1:0];
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			div_q <= div_nxt;
			rem_q <= rem_nxt;
		end
		if (cmd.div_step && sts.div_last) begin
			idx_q <= rem_nxt[rlhs_pkg::ADDR_W-1:0];
			n_q   <= '0;
		end else if (cmd.advance) begin
			if (idx_inc >= count) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_inc[rlhs_pkg::ADDR_W-1:0];
			end
			n_q <= n_inc;
		end
		if (cmd.res_set) begin
			acc_q <= cmd.res_acc;
		end
		if (cmd.out_load) begin
			out_lim_q   <= !acc_q;
			out_phone_q <= acc_q ? phone_q : '0;
			out_last_q  <= last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign rate_limited   = out_lim_q;
	assign phone_out      = out_phone_q;
	assign batch_last_out = out_last_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_rate_limit_hash_set_probe_top.sv
// Testbench for rate_limit_hash_set_probe_top: queued queries driven with random gaps,
// results checked in order against a linear-probing key set kept alongside the block.
// Depends on rlhs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_rate_limit_hash_set_probe_top;
	import rlhs_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] phone;
		logic              last;
	} query_t;

	typedef struct {
		logic              limited;
		logic [DATA_W-1:0] phone;
		logic              last;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [DATA_W-1:0]    query_key = '0;
	logic [DATA_W-1:0]    phone_in = '0;
	logic                 batch_last = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 rate_limited;
	logic [DATA_W-1:0]    phone_out;
	logic                 batch_last_out;

	rate_limit_hash_set_probe_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.query_key      (query_key),
		.phone_in       (phone_in),
		.batch_last     (batch_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rate_limited   (rate_limited),
		.phone_out      (phone_out),
		.batch_last_out (batch_last_out)
	);

	always #5 clk = ~clk;

	// key set as the block should hold it
	logic [DATA_W-1:0] set_keys [SLOTS];
	logic [CFG_W-1:0]  inserted_n;
	logic [CFG_W-1:0]  slots_cfg;
	logic [CFG_W-1:0]  budget_cfg;

	query_t            query_q [$];
	verdict_t          verdict_q [$];
	logic [DATA_W-1:0] key_pool [$];
	int unsigned       n_queued = 0;
	int unsigned       n_accepted = 0;
	int unsigned       n_fail = 0;
	int unsigned       in_gap = 0;
	int unsigned       out_gap = 0;
	logic              word_taken = 1'b0;
	logic              calm = 1'b0;

	function automatic verdict_t probe_set(input logic [DATA_W-1:0] key,
			input logic [DATA_W-1:0] phone, input logic last);
		int unsigned span;
		int unsigned idx;
		int unsigned n;
		logic        ok;
		logic        done;
		verdict_t    v;
		span = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
		ok = 1'b0;
		done = 1'b0;
		if (span != 0) begin
			idx = key[31:0] % span;
			n = 0;
			while (n < span && !done) begin
				if (idx >= span)
					idx = 0;
				if (set_keys[idx] == '0) begin
					if (inserted_n < budget_cfg) begin
						set_keys[idx] = key;
						inserted_n = inserted_n + 1'b1;
						ok = 1'b1;
					end
					done = 1'b1;
				end else if (set_keys[idx] == key) begin
					ok = 1'b1;
					done = 1'b1;
				end
				idx++;
				n++;
			end
		end
		v.limited = !ok;
		v.phone = ok ? phone : '0;
		v.last = last;
		return v;
	endfunction

	// sender: hold a stalled word, pause in bursts
	always @(negedge clk) begin
		query_t nxt;
		if (!in_valid || word_taken) begin
			if (in_gap != 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (query_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
				in_gap <= $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (query_q.size() != 0) begin
				nxt = query_q.pop_front();
				in_valid <= 1'b1;
				query_key <= nxt.key;
				phone_in <= nxt.phone;
				batch_last <= nxt.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall in bursts
	always @(negedge clk) begin
		if (out_gap != 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_gap <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		word_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected word: limited=%0b phone=%h last=%0b",
							rate_limited, phone_out, batch_last_out);
				end else begin
					v = verdict_q.pop_front();
					if (rate_limited !== v.limited || phone_out !== v.phone ||
							batch_last_out !== v.last) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: exp %0b/%h/%0b got %0b/%h/%0b",
								v.limited, v.phone, v.last, rate_limited, phone_out,
								batch_last_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				verdict_q.push_back(probe_set(query_key, phone_in, batch_last));
				n_accepted++;
			end
		end
	end

	task automatic wait_drained();
		@(negedge clk);
		while (n_accepted != n_queued || verdict_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SLOT_COUNT)
			slots_cfg = val;
		else if (idx == REG_INSERT_BUDGET)
			budget_cfg = val;
	endtask

	task automatic queue_query(input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] phone,
			input logic last);
		query_t q;
		q.key = key;
		q.phone = phone;
		q.last = last;
		query_q.push_back(q);
		n_queued++;
	endtask

	function automatic logic [DATA_W-1:0] pick_key();
		int unsigned       r;
		logic [DATA_W-1:0] k;
		r = $urandom_range(0, 99);
		if (r < 3)
			k = '0;
		else if (r < 6)
			k = '1;
		else if (r < 30 && key_pool.size() != 0)
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (r < 45)
			k = {$urandom, 32'($urandom_range(0, 2047))};
		else
			k = {$urandom, $urandom};
		key_pool.push_back(k);
		if (key_pool.size() > 200)
			void'(key_pool.pop_front());
		return k;
	endfunction

	function automatic logic [DATA_W-1:0] pick_phone();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		return {$urandom, $urandom};
	endfunction

	initial begin
		int unsigned counts [11] = '{1, 3, 16, 0, 64, 1024, 7, 2047, 200, 33, 1024};
		int unsigned budgets [11] = '{2047, 2047, 300, 2047, 0, 1024, 2047, 200, 2047, 600, 1024};
		foreach (set_keys[i])
			set_keys[i] = '0;
		inserted_n = '0;
		slots_cfg = SLOT_COUNT_RST;
		budget_cfg = INSERT_BUDGET_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		queue_query(64'h0, '1, 1'b1);
		queue_query('1, 64'h0, 1'b0);
		queue_query(64'h0000_0001_0000_03FF, 64'h8000_0000_0000_0001, 1'b0);
		queue_query('1, 64'h0123_4567_89AB_CDEF, 1'b1);
		queue_query(64'h0000_0001_0000_03FF, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
		queue_query(64'h5A5A_A5A5_5A5A_A5A5, 64'hA5A5_5A5A_A5A5_5A5A, 1'b1);
		write_reg(REG_SLOT_COUNT, 11'd0);
		queue_query('1, 64'h1111, 1'b0);
		queue_query(64'h3C3C_0000_0000_0077, 64'h2222, 1'b1);
		write_reg(REG_SLOT_COUNT, 11'd2047);
		queue_query('1, 64'h3333, 1'b0);
		queue_query(64'h8000_0000_0000_0010, 64'h4444, 1'b1);
		write_reg(REG_INSERT_BUDGET, 11'd0);
		queue_query(64'h0F0F_0F0F_0F0F_0F0F, 64'h5555, 1'b0);
		queue_query('1, 64'h6666, 1'b1);
		queue_query(64'h0, 64'h7777, 1'b0);
		write_reg(REG_SLOT_COUNT, 11'd1);
		queue_query(64'h42, 64'h8888, 1'b1);
		queue_query(64'h0000_0001_0000_03FF, 64'h9999, 1'b0);
		write_reg(REG_INSERT_BUDGET, 11'd2047);
		write_reg(REG_SLOT_COUNT, 11'd2);
		queue_query(64'h2, 64'hAAAA, 1'b1);
		queue_query(64'h4, 64'hBBBB, 1'b0);

		for (int p = 0; p < 11; p++) begin
			write_reg(REG_SLOT_COUNT, CFG_W'(counts[p]));
			write_reg(REG_INSERT_BUDGET, CFG_W'(budgets[p]));
			calm = (p == 10);
			for (int i = 0; i < 90; i++) begin
				if (p == 5 && i == 45)
					wait_drained();
				queue_query(pick_key(), pick_phone(), 1'($urandom_range(0, 1)));
			end
		end

		wait_drained();
		repeat (64) @(negedge clk);
		if (n_fail == 0 && verdict_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(120_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
